// File: rtl/core/sff_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sff_pkg
// Shared types, widths and coefficient tables of the selectable FIR filter.
// ----------------------------------------------------------------------------
package sff_pkg;

  localparam int TAPS      = 11;
  localparam int SAMPLE_W  = 12;
  localparam int COEF_W    = 16;
  localparam int SEL_W     = 2;
  localparam int OUT_W     = 14;
  localparam int FRAC_BITS = 15;
  // unsigned sample gets a sign bit before the multiply
  localparam int PROD_W    = SAMPLE_W + 1 + COEF_W;
  // headroom for the sum of up to 16 products
  localparam int ACC_W     = PROD_W + 4;
  localparam int QUOT_W    = ACC_W - FRAC_BITS;
  // registered adder tree levels for eleven inputs
  localparam int TREE_LVLS = 4;
  localparam int LVL1_N    = (TAPS + 1) / 2;
  localparam int LVL2_N    = (LVL1_N + 1) / 2;
  localparam int LVL3_N    = (LVL2_N + 1) / 2;

  typedef logic        [SAMPLE_W-1:0] sample_t;
  typedef logic signed [COEF_W-1:0]   coef_t;
  typedef logic signed [PROD_W-1:0]   prod_t;
  typedef logic signed [ACC_W-1:0]    acc_t;
  typedef logic signed [QUOT_W-1:0]   quot_t;
  typedef logic signed [OUT_W-1:0]    filt_t;
  typedef logic        [SEL_W-1:0]    sel_t;

  // coefficient set codes; the unused code falls back to band-pass
  localparam sel_t SEL_LOWPASS  = 2'd0;
  localparam sel_t SEL_HIGHPASS = 2'd1;
  localparam sel_t SEL_BANDPASS = 2'd2;

  localparam acc_t  RND_HALF    = acc_t'(1) <<< (FRAC_BITS - 1);
  localparam acc_t  RND_HALF_M1 = RND_HALF - acc_t'(1);
  localparam quot_t Q_MAX       = quot_t'((1 << (OUT_W - 1)) - 1);
  localparam quot_t Q_MIN       = -quot_t'(1 << (OUT_W - 1));

  typedef struct packed {
    logic shift;  // take the neighbor's sample (a new word was accepted)
    logic load;   // pipeline advance: capture a fresh product
  } cell_ctrl_t;

  // Q1.15 taps; index TAPS-1 multiplies the newest sample
  localparam coef_t LP_COEFS [TAPS] = '{
    16'sd194, 16'sd978, 16'sd2409, 16'sd4148, 16'sd5585, 16'sd6143,
    16'sd5585, 16'sd4148, 16'sd2409, 16'sd978, 16'sd194
  };
  localparam coef_t HP_COEFS [TAPS] = '{
    16'sd0, 16'sd0, -16'sd1142, 16'sd3634, -16'sd6852, 16'sd9513,
    -16'sd6852, 16'sd3634, -16'sd1142, 16'sd0, 16'sd0
  };
  localparam coef_t BP_COEFS [TAPS] = '{
    16'sd1324, -16'sd1410, -16'sd2898, 16'sd1524, 16'sd9821, 16'sd14092,
    16'sd9821, 16'sd1524, -16'sd2898, -16'sd1410, 16'sd1324
  };

  function automatic coef_t coef_of(input sel_t sel, input int k);
    coef_t c;
    begin
      if (sel == SEL_LOWPASS) begin
        c = LP_COEFS[k];
      end else if (sel == SEL_HIGHPASS) begin
        c = HP_COEFS[k];
      end else begin
        c = BP_COEFS[k];
      end
      return c;
    end
  endfunction

endpackage

// File: rtl/core/sff_sample_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sff_sample_if
// Sample input channel: valid/ready handshake with one converter sample.
// ----------------------------------------------------------------------------
interface sff_sample_if;
  logic             valid;
  logic             ready;
  sff_pkg::sample_t sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

// File: rtl/core/sff_result_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sff_result_if
// Result channel: valid/ready handshake with one filtered output word.
// ----------------------------------------------------------------------------
interface sff_result_if;
  logic           valid;
  logic           ready;
  sff_pkg::filt_t filtered;

  modport source (output valid, output filtered, input ready);
  modport sink   (input valid, input filtered, output ready);
endinterface

// File: rtl/core/sff_cfg_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sff_cfg_if
// Configuration write channel carrying the coefficient set select.
// ----------------------------------------------------------------------------
interface sff_cfg_if;
  logic          valid;
  logic          ready;
  sff_pkg::sel_t filter_select;

  modport source (output valid, output filter_select, input ready);
  modport sink   (input valid, input filter_select, output ready);
endinterface

// File: rtl/core/sff_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sff_cell
// One delay-line cell: holds a sample, hands it left, forms its tap product.
// ----------------------------------------------------------------------------
module sff_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  sff_pkg::cell_ctrl_t ctrl,
  input  sff_pkg::sample_t    shift_in,
  input  sff_pkg::coef_t      coef,
  output sff_pkg::sample_t    sample_out,
  output sff_pkg::prod_t      prod_out
);

  sff_pkg::sample_t sample_r, sample_nxt;
  sff_pkg::prod_t   prod_r, prod_nxt;

  always_comb begin
    sample_nxt = ctrl.shift ? shift_in : sample_r;
    prod_nxt   = sff_pkg::prod_t'($signed({1'b0, sample_r}) * coef);
  end

  // delay line is cleared at reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sample_r <= '0;
    end else begin
      sample_r <= sample_nxt;
    end
  end

  // hold product while the pipeline stalls
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      prod_r <= prod_nxt;
    end
  end

  assign sample_out = sample_r;
  assign prod_out   = prod_r;

endmodule

// File: rtl/core/sff_sum_tree.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sff_sum_tree
// Registered adder tree that sums the tap products, one level per stage.
// ----------------------------------------------------------------------------
module sff_sum_tree (
  input  logic           clk,
  input  logic           advance,
  input  sff_pkg::prod_t prod_in [sff_pkg::TAPS],
  output sff_pkg::acc_t  sum_out
);

  sff_pkg::acc_t lvl1_r [sff_pkg::LVL1_N];
  sff_pkg::acc_t lvl2_r [sff_pkg::LVL2_N];
  sff_pkg::acc_t lvl3_r [sff_pkg::LVL3_N];
  sff_pkg::acc_t lvl4_r;
  sff_pkg::acc_t lvl1_nxt [sff_pkg::LVL1_N];
  sff_pkg::acc_t lvl2_nxt [sff_pkg::LVL2_N];
  sff_pkg::acc_t lvl3_nxt [sff_pkg::LVL3_N];
  sff_pkg::acc_t lvl4_nxt;

  always_comb begin
    for (int i = 0; i < sff_pkg::LVL1_N; i++) begin
      if (2 * i + 1 < sff_pkg::TAPS) begin
        lvl1_nxt[i] = sff_pkg::acc_t'(prod_in[2 * i]) + sff_pkg::acc_t'(prod_in[2 * i + 1]);
      end else begin
        lvl1_nxt[i] = sff_pkg::acc_t'(prod_in[2 * i]);
      end
    end
    for (int i = 0; i < sff_pkg::LVL2_N; i++) begin
      if (2 * i + 1 < sff_pkg::LVL1_N) begin
        lvl2_nxt[i] = lvl1_r[2 * i] + lvl1_r[2 * i + 1];
      end else begin
        lvl2_nxt[i] = lvl1_r[2 * i];
      end
    end
    for (int i = 0; i < sff_pkg::LVL3_N; i++) begin
      if (2 * i + 1 < sff_pkg::LVL2_N) begin
        lvl3_nxt[i] = lvl2_r[2 * i] + lvl2_r[2 * i + 1];
      end else begin
        lvl3_nxt[i] = lvl2_r[2 * i];
      end
    end
    lvl4_nxt = lvl3_r[0] + lvl3_r[sff_pkg::LVL3_N - 1];
  end

  // payload only; advance together with the valid chain in the top level
  always_ff @(posedge clk) begin
    if (advance) begin
      lvl1_r <= lvl1_nxt;
      lvl2_r <= lvl2_nxt;
      lvl3_r <= lvl3_nxt;
      lvl4_r <= lvl4_nxt;
    end
  end

  assign sum_out = lvl4_r;

endmodule

// File: rtl/core/selectable_fir_filter_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// selectable_fir_filter_core
// 11-tap FIR over unsigned 12-bit samples with three selectable tap sets.
// ----------------------------------------------------------------------------
// The filter takes one sample word per clock while no result is stalled
// at the output and returns one filtered word per sample. The accepting
// edge shifts the delay-line cells; the tap multiplies, four adder tree
// levels and one rounding stage into the output register follow in order.
// Throughput is one word per cycle while the output is not stalled, set by
// the cell row which advances once per accepted word. The whole pipeline
// stalls as one while a result waits at the output, so in_ch.ready is low
// only while out_ch.ready is low. Result = sum of the eleven newest samples
// times the Q1.15 taps of the selected set, scaled by 2^-15, rounded to
// nearest with halves away from zero, saturated to -8192..8191. The delay
// line is all zeros after reset. filter_select (reset: band-pass) picks
// 0 low-pass, 1 high-pass, 2 or 3 band-pass; write it only while idle.
// ----------------------------------------------------------------------------
module selectable_fir_filter_core (
  input  logic         clk,
  input  logic         rst_n,
  sff_sample_if.sink   in_ch,
  sff_result_if.source out_ch,
  sff_cfg_if.sink      cfg_ch
);

  // pipeline stages behind the input: cells, products, four tree levels
  localparam int VLD_N = 2 + sff_pkg::TREE_LVLS;

  logic                advance;
  logic                accept;
  sff_pkg::cell_ctrl_t cell_ctrl;

  sff_pkg::sel_t    sel_r, sel_nxt;
  logic [VLD_N-1:0] vld_r, vld_nxt;
  logic             out_vld_r, out_vld_nxt;
  sff_pkg::filt_t   filt_r, filt_nxt;

  sff_pkg::sample_t sample_bus [sff_pkg::TAPS];
  sff_pkg::prod_t   prod_bus   [sff_pkg::TAPS];
  sff_pkg::acc_t    sum;
  sff_pkg::acc_t    sum_rnd;
  sff_pkg::quot_t   quot;

  // Advance the whole pipe whenever the output register is free or drains.
  assign advance      = !out_vld_r || out_ch.ready;
  assign in_ch.ready  = advance;
  assign accept       = in_ch.valid && advance;
  assign cfg_ch.ready = 1'b1;

  assign cell_ctrl.shift = accept;
  assign cell_ctrl.load  = advance;

  // Cell k holds window entry k once a word has shifted in; the rightmost
  // cell takes the new sample, every other cell takes its right neighbor.
  for (genvar k = 0; k < sff_pkg::TAPS; k++) begin : g_cell
    sff_pkg::sample_t shift_src;

    if (k == sff_pkg::TAPS - 1) begin : g_head
      assign shift_src = in_ch.sample;
    end else begin : g_body
      assign shift_src = sample_bus[k + 1];
    end

    sff_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctrl       (cell_ctrl),
      .shift_in   (shift_src),
      .coef       (sff_pkg::coef_of(sel_r, k)),
      .sample_out (sample_bus[k]),
      .prod_out   (prod_bus[k])
    );
  end

  sff_sum_tree u_tree (
    .clk     (clk),
    .advance (advance),
    .prod_in (prod_bus),
    .sum_out (sum)
  );

  // Round half away from zero: add half for positive sums and one less than
  // half for negative ones, then shift arithmetically.
  always_comb begin
    sum_rnd = sum + (sum[sff_pkg::ACC_W-1] ? sff_pkg::RND_HALF_M1 : sff_pkg::RND_HALF);
    quot    = sum_rnd[sff_pkg::ACC_W-1:sff_pkg::FRAC_BITS];
    priority if (quot > sff_pkg::Q_MAX) begin
      filt_nxt = sff_pkg::filt_t'(sff_pkg::Q_MAX);
    end else if (quot < sff_pkg::Q_MIN) begin
      filt_nxt = sff_pkg::filt_t'(sff_pkg::Q_MIN);
    end else begin
      filt_nxt = sff_pkg::filt_t'(quot);
    end
  end

  // Shift the valid chain with the payload; hold everything on a stall.
  always_comb begin
    sel_nxt     = (cfg_ch.valid && cfg_ch.ready) ? cfg_ch.filter_select : sel_r;
    vld_nxt     = advance ? {vld_r[VLD_N-2:0], accept} : vld_r;
    out_vld_nxt = advance ? vld_r[VLD_N-1] : out_vld_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sel_r     <= sff_pkg::SEL_BANDPASS;
      vld_r     <= '0;
      out_vld_r <= 1'b0;
    end else begin
      sel_r     <= sel_nxt;
      vld_r     <= vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      filt_r <= filt_nxt;
    end
  end

  assign out_ch.valid    = out_vld_r;
  assign out_ch.filtered = filt_r;

`ifndef SYNTHESIS
  // A write lands in the select register on the next cycle.
  a_cfg_write: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_ch.valid && cfg_ch.ready |=> sel_r == $past(cfg_ch.filter_select))
    else $error("filter select did not take the written value");

  // An accepted word enters the valid chain.
  a_accept_tracked: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> vld_r[0])
    else $error("accepted word lost from the valid chain");

  // The delay line moves only on an accepted word.
  a_cells_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !accept |=> $stable(sample_bus[sff_pkg::TAPS-1]) && $stable(sample_bus[0]))
    else $error("delay line moved without an accepted word");

  // A stall freezes the valid chain.
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !advance |=> $stable(vld_r) && out_vld_r)
    else $error("pipeline moved during a stall");

  // The last tree level reaches the output register when the pipe advances.
  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    advance && vld_r[VLD_N-1] |=> out_vld_r)
    else $error("finished word dropped before the output register");
`endif

endmodule
